[hdl/b64d_pkg.sv]
`default_nettype none

package b64d_pkg;

  // Depth of the quartet queue between front and back, and its pointer width.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Pad character and number of result bytes in a full quartet.
  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [1:0] FULL_COUNT = 2'd3;

  // One finished quartet, or one length-error report, passed from front to back.
  typedef struct packed {
    logic [23:0] group;   // four sextets, first in the high bits
    logic [1:0]  count;   // results to emit, 1 to 3
    logic        final_q; // this quartet closes the text
    logic        bad;     // the quartet held a character outside the alphabet
    logic        lerr;    // the text ended inside a quartet
  } b64d_job_t;

endpackage

`default_nettype wire

[hdl/b64d_front.sv]
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic      in_end_of_text,
  input  wire logic      q_full,
  output logic           push,
  output b64d_job_t      push_job
);

  logic [17:0] accum_r, accum_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        third_pad_r, third_pad_nxt;
  logic        qbad_r, qbad_nxt;

  logic        accept;
  logic [5:0]  sextet;
  logic        char_bad;
  logic        is_pad;
  logic        pos3;
  logic        qbad;

  // A transaction is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Map one ASCII character to its sextet value; unknown characters become zero.
  always_comb begin
    sextet   = 6'd0;
    char_bad = 1'b0;
    priority if (in_char_code >= 8'h41 && in_char_code <= 8'h5A) begin
      sextet = 6'(in_char_code - 8'h41);
    end else if (in_char_code >= 8'h61 && in_char_code <= 8'h7A) begin
      sextet = 6'(in_char_code - 8'h61 + 8'd26);
    end else if (in_char_code >= 8'h30 && in_char_code <= 8'h39) begin
      sextet = 6'(in_char_code - 8'h30 + 8'd52);
    end else if (in_char_code == 8'h2B) begin
      sextet = 6'd62;
    end else if (in_char_code == 8'h2F) begin
      sextet = 6'd63;
    end else if (in_char_code == PAD_CHAR) begin
      sextet = 6'd0;
    end else begin
      char_bad = 1'b1;
    end
  end

  assign is_pad = (in_char_code == PAD_CHAR);
  assign pos3   = (pos_r == 2'd3);
  assign qbad   = qbad_r | char_bad;

  // A job leaves on the fourth character or on the end of the text.
  assign push = accept && (pos3 || in_end_of_text);

  always_comb begin
    push_job.final_q = in_end_of_text;
    push_job.bad     = qbad;
    push_job.lerr    = !pos3;
    if (pos3) begin
      push_job.group = {accum_r, sextet};
      if (in_end_of_text) begin
        push_job.count = FULL_COUNT - {1'b0, is_pad} - {1'b0, third_pad_r};
      end else begin
        push_job.count = FULL_COUNT;
      end
    end else begin
      push_job.group = 24'd0;
      push_job.count = 2'd1;
    end
  end

  // Quartet state: collect sextets, restart after every job.
  always_comb begin
    accum_nxt     = accum_r;
    pos_nxt       = pos_r;
    third_pad_nxt = third_pad_r;
    qbad_nxt      = qbad_r;
    if (push) begin
      accum_nxt     = 18'd0;
      pos_nxt       = 2'd0;
      third_pad_nxt = 1'b0;
      qbad_nxt      = 1'b0;
    end else if (accept) begin
      accum_nxt = {accum_r[11:0], sextet};
      pos_nxt   = pos_r + 2'd1;
      qbad_nxt  = qbad;
      if (pos_r == 2'd2) begin
        third_pad_nxt = is_pad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= 18'd0;
      pos_r       <= 2'd0;
      third_pad_r <= 1'b0;
      qbad_r      <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      pos_r       <= pos_nxt;
      third_pad_r <= third_pad_nxt;
      qbad_r      <= qbad_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/b64d_queue.sv]
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  b64d_job_t  push_job,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output b64d_job_t  head_job
);

  localparam int unsigned CW = QUEUE_AW + 1;

  b64d_job_t            entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic                 do_pop;

  assign full       = (fill_r == CW'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_job   = entries[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    fill_nxt   = fill_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Job storage; the front never pushes while the queue is full.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

[hdl/b64d_back.sv]
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  b64d_job_t       head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_data_byte,
  output logic            out_run_last,
  output logic            out_stream_end,
  output logic            out_bad_char,
  output logic            out_length_error
);

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r;
  logic       last_r, end_r, bad_r, lerr_r;

  logic       load;
  logic       take;
  logic       is_last;
  logic [7:0] sel_byte;

  // The output register refills when empty or when its transaction completes.
  assign load    = !valid_r || !out_stall;
  assign take    = load && head_valid;
  assign is_last = (idx_r == head_job.count - 2'd1);
  assign pop     = take && is_last;

  // Pick the byte of the group, most significant first.
  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = head_job.group[23:16];
      2'd1:    sel_byte = head_job.group[15:8];
      default: sel_byte = head_job.group[7:0];
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = head_valid;
    end
    if (take) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= sel_byte;
      last_r <= is_last;
      end_r  <= is_last && head_job.final_q;
      bad_r  <= head_job.bad;
      lerr_r <= head_job.lerr;
    end
  end

  assign out_valid        = valid_r;
  assign out_data_byte    = byte_r;
  assign out_run_last     = last_r;
  assign out_stream_end   = end_r;
  assign out_bad_char     = bad_r;
  assign out_length_error = lerr_r;

endmodule

`default_nettype wire

[hdl/base64_stream_decoder.sv]
`default_nettype none

// Streaming base64 decoder. One text character is taken per clock while
// in_stall is low, with in_end_of_text on the final one; every fourth character
// yields three bytes, one per clock while out_stall is low, through a
// registered output, so an unstalled stream runs at one character per cycle.
// The front classifies characters and collects quartets, and a four-entry queue
// carries finished quartets to the back, which emits the bytes; with the queue
// and the output idle, a quartet's first byte passes from its queue entry into
// the output register. On the final quartet a '=' in the third or fourth place
// drops one trailing byte each. Characters outside the alphabet decode as zero
// and set out_bad_char on the results of their quartet. A text that ends inside
// a quartet gives a single result with out_length_error set and a zero byte.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_data_byte,
  output logic            out_run_last,
  output logic            out_stream_end,
  output logic            out_bad_char,
  output logic            out_length_error
);

  logic      push;
  b64d_job_t push_job;
  logic      q_full;
  logic      pop;
  logic      head_valid;
  b64d_job_t head_job;

  // Character intake and quartet assembly.
  b64d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  // Queue of finished quartets.
  b64d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Byte emission.
  b64d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_run_last     (out_run_last),
    .out_stream_end   (out_stream_end),
    .out_bad_char     (out_bad_char),
    .out_length_error (out_length_error)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;
  import b64d_pkg::*;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // One decoded output transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
    logic       stream_end;
    logic       bad_char;
    logic       length_error;
  } byte_result_t;

  // Tracks the decoder state and holds the bytes it still owes.
  class decode_scoreboard;
    byte_result_t pending_bytes[$];
    logic [17:0] sextets;
    logic [1:0]  slot;
    logic        third_pad;
    logic        group_bad;
    int errors;
    int checked;
    int lerr_seen;
    int bad_seen;

    function new();
      clear_quartet();
      errors = 0;
      checked = 0;
      lerr_seen = 0;
      bad_seen = 0;
    endfunction

    function void clear_quartet();
      sextets = '0;
      slot = '0;
      third_pad = 1'b0;
      group_bad = 1'b0;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    task report(input string msg);
      if (errors < 100) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void push_byte(logic [7:0] b, logic lst, logic se, logic bd, logic le);
      byte_result_t r;
      r.data_byte = b;
      r.run_last = lst;
      r.stream_end = se;
      r.bad_char = bd;
      r.length_error = le;
      pending_bytes.push_back(r);
    endfunction

    // Work out the bytes that one accepted character produces.
    function void take_char(logic [7:0] ch, logic eot);
      int v;
      logic [5:0] sx;
      logic is_bad;
      logic is_pad;
      logic qb;
      logic [23:0] grp;
      int cnt;
      v = 0;
      is_bad = 1'b0;
      if (ch >= "A" && ch <= "Z") v = ch - "A";
      else if (ch >= "a" && ch <= "z") v = ch - "a" + 26;
      else if (ch >= "0" && ch <= "9") v = ch - "0" + 52;
      else if (ch == "+") v = 62;
      else if (ch == "/") v = 63;
      else if (ch != PAD_CHAR) is_bad = 1'b1;
      sx = v[5:0];
      is_pad = (ch == PAD_CHAR);
      qb = group_bad | is_bad;

      if (slot != 2'd3) begin
        // The text ends inside a quartet: one length-error transaction.
        if (eot) begin
          push_byte(8'h00, 1'b1, 1'b1, qb, 1'b1);
          clear_quartet();
        end else begin
          if (slot == 2'd2) third_pad = is_pad;
          sextets = {sextets[11:0], sx};
          group_bad = qb;
          slot = slot + 2'd1;
        end
      end else begin
        // Fourth character: emit the group, trimmed by padding on the final quartet.
        grp = {sextets, sx};
        cnt = 3;
        if (eot) cnt = 3 - int'(is_pad) - int'(third_pad);
        for (int k = 0; k < cnt; k++) begin
          push_byte(grp[23 - 8 * k -: 8], k == cnt - 1, (k == cnt - 1) && eot, qb, 1'b0);
        end
        clear_quartet();
      end
    endfunction

    task check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", checked, name, got, want));
    endtask

    // Compare one accepted output transaction with the oldest expected byte.
    task check_byte(input byte_result_t got);
      byte_result_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected result 0x%0h with nothing outstanding", got));
      end else begin
        want = pending_bytes.pop_front();
        check_field("data_byte", got.data_byte, want.data_byte);
        check_field("run_last", 8'(got.run_last), 8'(want.run_last));
        check_field("stream_end", 8'(got.stream_end), 8'(want.stream_end));
        check_field("bad_char", 8'(got.bad_char), 8'(want.bad_char));
        check_field("length_error", 8'(got.length_error), 8'(want.length_error));
        if (want.length_error) lerr_seen++;
        if (want.bad_char) bad_seen++;
      end
      checked++;
    endtask
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_run_last;
  logic       out_stream_end;
  logic       out_bad_char;
  logic       out_length_error;

  base64_stream_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_run_last     (out_run_last),
    .out_stream_end   (out_stream_end),
    .out_bad_char     (out_bad_char),
    .out_length_error (out_length_error)
  );

  decode_scoreboard sb = new();

  logic snd_idle = 1'b1;
  logic rcv_idle = 1'b1;
  int   chars_sent = 0;
  int   cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run limit in case the decoder hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d bytes outstanding.",
               RUN_LIMIT, sb.pending());
      $display("** base64_stream_decoder: FAILED **");
      $finish;
    end
  end

  // Sample both handshakes mid-cycle, when everything has settled.
  logic         in_take_s = 1'b0;
  logic         out_take_s = 1'b0;
  logic [7:0]   in_char_s;
  logic         in_eot_s;
  byte_result_t out_s;

  always @(negedge clk) begin
    in_take_s = rst_n && in_valid && !in_stall;
    in_char_s = in_char_code;
    in_eot_s = in_end_of_text;
    out_take_s = rst_n && out_valid && !out_stall;
    out_s.data_byte = out_data_byte;
    out_s.run_last = out_run_last;
    out_s.stream_end = out_stream_end;
    out_s.bad_char = out_bad_char;
    out_s.length_error = out_length_error;
  end

  // Transactions complete at the rising edge.
  always @(posedge clk) begin
    if (in_take_s) sb.take_char(in_char_s, in_eot_s);
    if (out_take_s) sb.check_byte(out_s);
  end

  // Result side: while rcv_idle is set, stall a random number of cycles before each transaction.
  initial begin
    int gap;
    logic took;
    @(posedge clk iff rst_n);
    forever begin
      gap = rcv_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      took = 1'b0;
      while (!took) begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] sextet_char(int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic eot);
    int gap;
    logic took;
    gap = snd_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= ch;
    in_end_of_text <= eot;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
    chars_sent++;
  endtask

  task automatic send_str(input string s, input logic eot);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eot && (i == s.len() - 1));
  endtask

  // Hold off new characters until every owed byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A well-formed text of one to four quartets, sometimes damaged.
  task automatic send_text();
    int nq;
    int keep;
    logic is_last;
    logic [7:0] qc[4];
    nq = $urandom_range(1, 4);
    for (int q = 0; q < nq; q++) begin
      is_last = (q == nq - 1);
      for (int j = 0; j < 4; j++) begin
        qc[j] = sextet_char($urandom_range(0, 63));
        if ($urandom_range(0, 19) == 0) qc[j] = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 15) == 0) qc[j] = PAD_CHAR;
      end
      keep = 4;
      if (is_last) begin
        case ($urandom_range(0, 3))
          1: qc[3] = PAD_CHAR;
          2: begin
            qc[2] = PAD_CHAR;
            qc[3] = PAD_CHAR;
          end
          3: qc[2] = PAD_CHAR;
          default: ;
        endcase
        if ($urandom_range(0, 7) == 0) keep = $urandom_range(1, 3);
      end
      for (int j = 0; j < keep; j++) send_char(qc[j], is_last && (j == keep - 1));
    end
  endtask

  // Arbitrary bytes with random end flags, closed by an end flag.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++)
      send_char(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0));
  endtask

  task automatic run_phase(input int upto);
    while (chars_sent < upto) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      else send_text();
    end
    drain();
  endtask

  // Main sequence: directed texts, then random phases with different idle patterns.
  initial begin
    @(posedge clk iff rst_n);

    // Plain quartet, padding inside the text, and a third-place pad on the final quartet.
    send_str("TWFu", 1'b0);
    send_str("+/==", 1'b0);
    send_str("AB=C", 1'b1);
    // Character outside the alphabet, with a single trailing pad.
    send_char(8'hFF, 1'b0);
    send_str("zA=", 1'b1);
    // Texts that stop inside a quartet, one with a zero byte in it.
    send_str("Q=", 1'b1);
    send_str("QU", 1'b0);
    send_char(8'h00, 1'b1);
    // Two pads leave a single byte.
    send_str("9z==", 1'b1);
    drain();

    snd_idle = 1'b1;
    rcv_idle = 1'b1;
    run_phase(140);
    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    run_phase(250);
    snd_idle = 1'b1;
    rcv_idle = 1'b0;
    run_phase(360);
    snd_idle = 1'b0;
    rcv_idle = 1'b1;
    run_phase(470);

    while (sb.pending() != 0) begin
      sb.report("expected byte never came out");
      void'(sb.pending_bytes.pop_front());
    end
    $display("Sent %0d characters; checked %0d output bytes, %0d length errors, %0d bad-char.",
             chars_sent, sb.checked, sb.lerr_seen, sb.bad_seen);
    $display("Both sides ran with random gaps of 0 to 19 cycles and with back-to-back stretches.");
    if (sb.errors == 0) begin
      $display("** base64_stream_decoder: PASSED **");
    end else begin
      $display("** base64_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_queue.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder.sv
dv/tb.sv
